// ----- rtl/core/cls_pkg.sv -----
// Shared constants, codes and controller/datapath bundles for the charlieplex LED scanner.
package cls_pkg;

    localparam int MAX_PINS = 8;
    localparam int PIN_W    = 4;            // holds a pin count up to MAX_PINS
    localparam int ROW_W    = 4;            // holds a row count up to MAX_PINS
    localparam int SEL_W    = 3;            // selects one of MAX_PINS pins or rows
    localparam int SLOT_N   = MAX_PINS - 1; // anode slots per cathode word
    localparam int IDX_W    = 6;
    localparam int GRID_W   = 7;            // holds pins * (pins - 1)

    localparam logic [1:0] KIND_WRITE  = 2'd0;
    localparam logic [1:0] KIND_TOGGLE = 2'd1;
    localparam logic [1:0] KIND_TICK   = 2'd2;

    localparam logic REG_PIN_COUNT = 1'b0;
    localparam logic REG_ROW_COUNT = 1'b1;

    localparam logic [PIN_W-1:0] PIN_COUNT_RESET = 4'd8;
    localparam logic [ROW_W-1:0] ROW_COUNT_RESET = 4'd8;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;       // capture the incoming transaction
        logic div_step;   // one restoring division step
        logic apply;      // update the addressed LED bit
        logic scan_step;  // examine one pin of the scan row
        logic finish;     // commit tick state and load the result register
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic div_last;
        logic scan_last;
        logic oor;
        logic out_free;
    } t_status;

endpackage

// ----- rtl/core/cls_if.sv -----
// Handshake channel interfaces: input items, result items and configuration writes.
interface cls_item_if;
    logic       valid;
    logic       ready;
    logic [1:0] kind;
    logic [5:0] led_index;
    logic       led_value;

    modport source (output valid, kind, led_index, led_value, input ready);
    modport sink   (input valid, kind, led_index, led_value, output ready);
endinterface

interface cls_result_if;
    logic       valid;
    logic       ready;
    logic       led_state;
    logic       out_of_range;
    logic [7:0] drive_high;
    logic [7:0] drive_low;
    logic [2:0] scan_row;

    modport source (output valid, led_state, out_of_range, drive_high, drive_low, scan_row,
                    input ready);
    modport sink   (input valid, led_state, out_of_range, drive_high, drive_low, scan_row,
                    output ready);
endinterface

interface cls_cfg_if;
    logic       valid;
    logic       ready;
    logic       index;
    logic [3:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ----- rtl/core/cls_ctrl.sv -----
// Sequencing controller: divide, update, scan and result hand-off.
module cls_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic [1:0]       i_in_kind,
    input  cls_pkg::t_status i_status,
    output logic             o_in_ready,
    output cls_pkg::t_cmd    o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV,
        S_APPLY,
        S_SCAN,
        S_FINISH
    } t_state;

    t_state r_state;
    logic   w_accept;

    assign o_in_ready = (r_state == S_IDLE);
    assign w_accept   = i_in_valid && o_in_ready;

    always_comb begin
        o_cmd           = '0;
        o_cmd.load      = w_accept;
        o_cmd.div_step  = (r_state == S_DIV);
        o_cmd.apply     = (r_state == S_APPLY);
        o_cmd.scan_step = (r_state == S_SCAN);
        o_cmd.finish    = (r_state == S_FINISH) && i_status.out_free;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        if (i_in_kind == cls_pkg::KIND_WRITE ||
                            i_in_kind == cls_pkg::KIND_TOGGLE) begin
                            r_state <= S_DIV;
                        end else if (i_in_kind == cls_pkg::KIND_TICK) begin
                            r_state <= S_SCAN;
                        end else begin
                            r_state <= S_FINISH;
                        end
                    end
                end
                S_DIV: begin
                    if (i_status.div_last) begin
                        r_state <= i_status.oor ? S_FINISH : S_APPLY;
                    end
                end
                S_APPLY: begin
                    r_state <= S_FINISH;
                end
                S_SCAN: begin
                    if (i_status.scan_last) begin
                        r_state <= S_FINISH;
                    end
                end
                S_FINISH: begin
                    if (i_status.out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// ----- rtl/core/cls_datapath.sv -----
// Datapath: configuration, LED bit store, serial divider, scan walker and result register.
module cls_datapath (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  cls_pkg::t_cmd    i_cmd,
    output cls_pkg::t_status o_status,
    // configuration writes
    input  logic             i_cfg_write,
    input  logic             i_cfg_index,
    input  logic [3:0]       i_cfg_data,
    // incoming transaction payload
    input  logic [1:0]       i_kind,
    input  logic [5:0]       i_led_index,
    input  logic             i_led_value,
    // result channel
    input  logic             i_out_ready,
    output logic             o_out_valid,
    output logic             o_led_state,
    output logic             o_out_of_range,
    output logic [7:0]       o_drive_high,
    output logic [7:0]       o_drive_low,
    output logic [2:0]       o_scan_row
);

    localparam int MP = cls_pkg::MAX_PINS;
    localparam int SW = cls_pkg::SEL_W;

    logic [cls_pkg::PIN_W-1:0]  r_pin_count;
    logic [cls_pkg::ROW_W-1:0]  r_row_count;
    logic [cls_pkg::SLOT_N-1:0] r_led_bits [MP];
    logic [SW-1:0]              r_scan;
    logic [2*MP-1:0]            r_pin_drive;

    logic [1:0]                 r_kind;
    logic                       r_val;
    logic                       r_oor;
    logic [cls_pkg::IDX_W-1:0]  r_quot;
    logic [SW-1:0]              r_rem;
    logic [SW-1:0]              r_step;
    logic [SW-1:0]              r_cath;
    logic [SW-1:0]              r_pin;
    logic [SW-1:0]              r_slot;
    logic [MP-1:0]              r_hi;
    logic                       r_state_bit;

    logic                       r_out_valid;
    logic                       r_out_state;
    logic                       r_out_oor;
    logic                       r_out_tick;
    logic [SW-1:0]              r_out_row;

    logic [cls_pkg::PIN_W-1:0]  w_pins;
    logic [SW-1:0]              w_slots;
    logic [cls_pkg::ROW_W-1:0]  w_rows;
    logic [cls_pkg::GRID_W-1:0] w_grid;
    logic [SW-1:0]              w_tick_row;
    logic [SW:0]                w_trial;
    logic                       w_ge;
    logic [cls_pkg::SLOT_N-1:0] w_cur;
    logic [cls_pkg::SLOT_N-1:0] w_mask;
    logic [cls_pkg::SLOT_N-1:0] w_new;
    logic [MP-1:0]              w_scan_word;
    logic [cls_pkg::ROW_W-1:0]  w_next_row;
    logic [MP-1:0]              w_lo;
    logic                       w_is_tick;

    // Saturate the pin and row counts into their meaningful ranges.
    always_comb begin
        if (r_pin_count < cls_pkg::PIN_W'(2)) begin
            w_pins = cls_pkg::PIN_W'(2);
        end else if (r_pin_count > cls_pkg::PIN_W'(MP)) begin
            w_pins = cls_pkg::PIN_W'(MP);
        end else begin
            w_pins = r_pin_count;
        end
        if (r_row_count == '0) begin
            w_rows = cls_pkg::ROW_W'(1);
        end else if (r_row_count > w_pins) begin
            w_rows = w_pins;
        end else begin
            w_rows = r_row_count;
        end
    end

    assign w_slots    = SW'(w_pins - cls_pkg::PIN_W'(1));
    assign w_grid     = cls_pkg::GRID_W'(w_pins) * cls_pkg::GRID_W'(w_slots);
    assign w_tick_row = ({1'b0, r_scan} < w_rows) ? r_scan : '0;

    // Restoring division step: bring in the next dividend bit, subtract when it fits.
    assign w_trial = {r_rem, r_quot[cls_pkg::IDX_W-1]};
    assign w_ge    = (w_trial >= {1'b0, w_slots});

    assign w_cur  = r_led_bits[r_quot[SW-1:0]];
    assign w_mask = cls_pkg::SLOT_N'(1) << r_rem;
    always_comb begin
        if (r_kind == cls_pkg::KIND_WRITE) begin
            w_new = r_val ? (w_cur | w_mask) : (w_cur & ~w_mask);
        end else begin
            w_new = w_cur ^ w_mask;
        end
    end

    assign w_scan_word = {1'b0, r_led_bits[r_cath]};
    assign w_next_row  = cls_pkg::ROW_W'(r_cath) + cls_pkg::ROW_W'(1);
    assign w_lo        = MP'(1) << r_cath;
    assign w_is_tick   = (r_kind == cls_pkg::KIND_TICK);

    assign o_status.div_last  = (r_step == SW'(cls_pkg::IDX_W - 1));
    assign o_status.scan_last = (r_pin == SW'(w_pins - cls_pkg::PIN_W'(1)));
    assign o_status.oor       = r_oor;
    assign o_status.out_free  = !r_out_valid || i_out_ready;

    // Configuration and architectural state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pin_count <= cls_pkg::PIN_COUNT_RESET;
            r_row_count <= cls_pkg::ROW_COUNT_RESET;
            r_scan      <= '0;
            r_pin_drive <= '0;
            for (int k = 0; k < MP; k++) begin
                r_led_bits[k] <= '0;
            end
        end else begin
            if (i_cfg_write) begin
                if (i_cfg_index == cls_pkg::REG_PIN_COUNT) begin
                    r_pin_count <= i_cfg_data;
                end else begin
                    r_row_count <= i_cfg_data;
                end
            end
            if (i_cmd.apply) begin
                r_led_bits[r_quot[SW-1:0]] <= w_new;
            end
            if (i_cmd.finish && w_is_tick) begin
                r_pin_drive <= {w_lo, r_hi};
                r_scan      <= (w_next_row == w_rows) ? '0 : SW'(w_next_row);
            end
        end
    end

    // Per-transaction working registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_kind      <= i_kind;
            r_val       <= i_led_value;
            r_oor       <= (i_kind == cls_pkg::KIND_WRITE || i_kind == cls_pkg::KIND_TOGGLE) &&
                           ({1'b0, i_led_index} >= w_grid);
            r_quot      <= i_led_index;
            r_rem       <= '0;
            r_step      <= '0;
            r_cath      <= w_tick_row;
            r_pin       <= '0;
            r_slot      <= '0;
            r_hi        <= '0;
            r_state_bit <= 1'b0;
        end else begin
            if (i_cmd.div_step) begin
                r_quot <= {r_quot[cls_pkg::IDX_W-2:0], w_ge};
                r_rem  <= w_ge ? SW'(w_trial - {1'b0, w_slots}) : w_trial[SW-1:0];
                r_step <= r_step + SW'(1);
            end
            if (i_cmd.apply) begin
                r_state_bit <= w_new[r_rem];
            end
            if (i_cmd.scan_step) begin
                // skip the cathode pin; the others take slot bits in order
                if (r_pin != r_cath) begin
                    r_hi[r_pin] <= w_scan_word[r_slot];
                    r_slot      <= r_slot + SW'(1);
                end
                r_pin <= r_pin + SW'(1);
            end
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.finish) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_out_state <= r_state_bit;
            r_out_oor   <= r_oor;
            r_out_tick  <= w_is_tick;
            r_out_row   <= w_is_tick ? r_cath : '0;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_led_state    = r_out_state;
    assign o_out_of_range = r_out_oor;
    assign o_drive_high   = r_out_tick ? r_pin_drive[MP-1:0] : '0;
    assign o_drive_low    = r_out_tick ? r_pin_drive[2*MP-1:MP] : '0;
    assign o_scan_row     = r_out_row;

endmodule

// ----- rtl/core/charlieplex_led_scanner.sv -----
// Top level of the charlieplex LED scanner: channel wiring of controller and datapath.
//
// Usage:
//   i_item   - input transactions: kind (write, toggle, scan tick), led_index, led_value.
//   o_result - one result transaction per input: led_state, out_of_range, and for a
//              tick the drive_high / drive_low pin masks and the scan_row shown.
//   i_cfg    - register writes, always ready: index 0 pin_count, index 1 row_count.
//              Write only while the block is idle.
// Timing:
//   A write or toggle runs a 6-step restoring divider (index by pins-1) and then one
//   update step before the result is loaded. A tick walks the pins one per cycle and
//   then loads the result. Out-of-range indexes skip the update step; unused kinds go
//   straight to the result register.
//   One transaction is in work at a time; the divider and the pin walk set the rate.
// Reset:
//   pin_count and row_count return to 8, all LED bits clear, scan row 0, all pins at
//   high impedance. Reset is synchronous and active low.
// Stalls:
//   A finished result sits in the output register; the block takes the next input
//   while it waits, and holds the following result until the register drains.
module charlieplex_led_scanner (
    input logic          i_clk,
    input logic          i_rst_n,
    cls_item_if.sink     i_item,
    cls_result_if.source o_result,
    cls_cfg_if.sink      i_cfg
);

    cls_pkg::t_cmd    w_cmd;
    cls_pkg::t_status w_status;
    logic             w_in_ready;

    // Configuration is taken at any time.
    assign i_cfg.ready  = 1'b1;
    assign i_item.ready = w_in_ready;

    cls_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_item.valid),
        .i_in_kind  (i_item.kind),
        .i_status   (w_status),
        .o_in_ready (w_in_ready),
        .o_cmd      (w_cmd)
    );

    cls_datapath u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .o_status       (w_status),
        .i_cfg_write    (i_cfg.valid),
        .i_cfg_index    (i_cfg.index),
        .i_cfg_data     (i_cfg.data),
        .i_kind         (i_item.kind),
        .i_led_index    (i_item.led_index),
        .i_led_value    (i_item.led_value),
        .i_out_ready    (o_result.ready),
        .o_out_valid    (o_result.valid),
        .o_led_state    (o_result.led_state),
        .o_out_of_range (o_result.out_of_range),
        .o_drive_high   (o_result.drive_high),
        .o_drive_low    (o_result.drive_low),
        .o_scan_row     (o_result.scan_row)
    );

endmodule

// ----- tb/sv/charlieplex_led_scanner_test.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for the charlieplex LED scanner: random and directed LED traffic.
module charlieplex_led_scanner_test;

    // Kind code that the block does not use; it must come back as an all-zero result.
    localparam logic [1:0] KIND_UNUSED = 2'd3;

    // Cycles with no transaction on any channel before the run is declared hung.
    localparam int STALL_LIMIT = 2000;

    typedef struct packed {
        logic [1:0] kind;
        logic [5:0] led_index;
        logic       led_value;
    } t_led_cmd;

    typedef struct packed {
        logic       led_state;
        logic       out_of_range;
        logic [7:0] drive_high;
        logic [7:0] drive_low;
        logic [2:0] scan_row;
    } t_scan_out;

    logic i_clk = 1'b0;
    logic i_rst_n;

    cls_item_if   item_ch ();
    cls_result_if res_ch ();
    cls_cfg_if    cfg_ch ();

    charlieplex_led_scanner dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (item_ch),
        .o_result (res_ch),
        .i_cfg    (cfg_ch)
    );

    always #10 i_clk = ~i_clk;

    // Shadow of the block: LED words per cathode, scan pointer, pin drive and registers.
    logic [cls_pkg::SLOT_N-1:0] lamp_rows [cls_pkg::MAX_PINS];
    logic [2:0]                 scan_ptr;
    logic [15:0]                drive_latch;
    logic [3:0]                 pin_cfg;
    logic [3:0]                 row_cfg;

    t_led_cmd  cmd_queue [$];     // commands waiting to be offered to the block
    t_scan_out due_results [$];   // predicted results, oldest first
    bit        steady;            // suppress all random idling on both sides
    int        fault_count;
    int        stall_cycles;

    // Pin count as the block uses it: saturated to 2..MAX_PINS.
    function automatic int eff_pins();
        int p;
        p = int'(pin_cfg);
        if (p < 2) p = 2;
        if (p > cls_pkg::MAX_PINS) p = cls_pkg::MAX_PINS;
        return p;
    endfunction

    // Apply one command to the shadow state and return the result it produces.
    function automatic t_scan_out compute_led_result(t_led_cmd cmd);
        int         pins;
        int         slots;
        int         rows;
        int         cath;
        int         slot;
        logic [6:0] word;
        t_scan_out  r;
        r     = '0;
        pins  = eff_pins();
        slots = pins - 1;
        case (cmd.kind)
            cls_pkg::KIND_WRITE, cls_pkg::KIND_TOGGLE: begin
                if (int'(cmd.led_index) >= pins * slots) begin
                    r.out_of_range = 1'b1;
                end else begin
                    cath = int'(cmd.led_index) / slots;
                    slot = int'(cmd.led_index) % slots;
                    if (cmd.kind == cls_pkg::KIND_WRITE)
                        lamp_rows[cath][slot] = cmd.led_value;
                    else
                        lamp_rows[cath][slot] = ~lamp_rows[cath][slot];
                    r.led_state = lamp_rows[cath][slot];
                end
            end
            cls_pkg::KIND_TICK: begin
                rows = int'(row_cfg);
                if (rows < 1) rows = 1;
                if (rows > pins) rows = pins;
                // A pointer left beyond a shrunken row count falls back to row 0.
                cath = (int'(scan_ptr) < rows) ? int'(scan_ptr) : 0;
                word = lamp_rows[cath];
                slot = 0;
                // Walk the pins, skipping the cathode; each other pin takes the next slot.
                for (int k = 0; k < pins; k++) begin
                    if (k != cath) begin
                        if (word[slot]) r.drive_high[k] = 1'b1;
                        slot++;
                    end
                end
                r.drive_low[cath] = 1'b1;
                r.scan_row        = 3'(cath);
                drive_latch       = {r.drive_low, r.drive_high};
                scan_ptr          = 3'((cath + 1) % rows);
            end
            default: begin
                // Unused kind: no state change, all-zero result.
            end
        endcase
        return r;
    endfunction

    // Random command; mostly in-grid for the current pin count, some anywhere.
    function automatic t_led_cmd random_cmd();
        int       pins;
        int       roll;
        t_led_cmd c;
        pins        = eff_pins();
        roll        = $urandom_range(0, 99);
        c.led_value = 1'($urandom_range(0, 1));
        if (roll < 35)      c.kind = cls_pkg::KIND_WRITE;
        else if (roll < 60) c.kind = cls_pkg::KIND_TOGGLE;
        else if (roll < 96) c.kind = cls_pkg::KIND_TICK;
        else                c.kind = KIND_UNUSED;
        if ($urandom_range(0, 99) < 85)
            c.led_index = 6'($urandom_range(0, pins * (pins - 1) - 1));
        else
            c.led_index = 6'($urandom_range(0, 63));
        return c;
    endfunction

    task automatic push_cmd(input logic [1:0] kind, input int idx, input logic val);
        t_led_cmd c;
        c.kind      = kind;
        c.led_index = 6'(idx);
        c.led_value = val;
        cmd_queue.push_back(c);
    endtask

    // Hold until every queued command has been taken and every result has come back.
    // Sample between edges so the driver's and the checker's updates have settled.
    task automatic wait_drained();
        while (cmd_queue.size() != 0 || item_ch.valid || due_results.size() != 0)
            @(negedge i_clk);
    endtask

    // Write one register; the shadow copy changes at the accepting edge.
    task automatic write_reg(input logic index, input logic [3:0] data);
        @(posedge i_clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= index;
        cfg_ch.data  <= data;
        do @(posedge i_clk); while (!cfg_ch.ready);
        if (index == cls_pkg::REG_PIN_COUNT) pin_cfg = data;
        else                                 row_cfg = data;
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic set_config(input logic [3:0] pins, input logic [3:0] rows);
        wait_drained();
        write_reg(cls_pkg::REG_PIN_COUNT, pins);
        write_reg(cls_pkg::REG_ROW_COUNT, rows);
    endtask

    function automatic void note_fault(string msg);
        if (fault_count < 10) $display("%t: %s", $realtime, msg);
        fault_count++;
    endfunction

    // Offer commands from the queue; predict each transaction at the edge that accepts it.
    always @(posedge i_clk) begin : drive_items
        t_led_cmd taken;
        t_led_cmd nxt;
        if (!i_rst_n) begin
            item_ch.valid <= 1'b0;
        end else begin
            if (item_ch.valid && item_ch.ready) begin
                taken.kind      = item_ch.kind;
                taken.led_index = item_ch.led_index;
                taken.led_value = item_ch.led_value;
                due_results.push_back(compute_led_result(taken));
            end
            // Advance only when nothing is offered or the offer was just taken.
            if (!item_ch.valid || item_ch.ready) begin
                if (cmd_queue.size() != 0 && (steady || $urandom_range(0, 99) >= 27)) begin
                    nxt                = cmd_queue.pop_front();
                    item_ch.valid     <= 1'b1;
                    item_ch.kind      <= nxt.kind;
                    item_ch.led_index <= nxt.led_index;
                    item_ch.led_value <= nxt.led_value;
                end else begin
                    item_ch.valid <= 1'b0;
                end
            end
        end
    end

    // Stall the result channel at random, except in the steady stretch.
    always @(posedge i_clk) begin
        res_ch.ready <= steady || ($urandom_range(0, 99) >= 27);
    end

    // Check each result transaction against the oldest prediction.
    always @(posedge i_clk) begin : check_results
        t_scan_out got;
        t_scan_out want;
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            got.led_state    = res_ch.led_state;
            got.out_of_range = res_ch.out_of_range;
            got.drive_high   = res_ch.drive_high;
            got.drive_low    = res_ch.drive_low;
            got.scan_row     = res_ch.scan_row;
            if (due_results.size() == 0) begin
                note_fault($sformatf("unexpected result state=%b oor=%b hi=%h lo=%h row=%0d",
                    got.led_state, got.out_of_range, got.drive_high, got.drive_low,
                    got.scan_row));
            end else begin
                want = due_results.pop_front();
                if (got.led_state !== want.led_state || got.out_of_range !== want.out_of_range
                        || got.drive_high !== want.drive_high
                        || got.drive_low !== want.drive_low
                        || got.scan_row !== want.scan_row)
                    note_fault({
                        $sformatf("mismatch exp state=%b oor=%b hi=%h lo=%h row=%0d,",
                            want.led_state, want.out_of_range, want.drive_high,
                            want.drive_low, want.scan_row),
                        $sformatf(" got state=%b oor=%b hi=%h lo=%h row=%0d",
                            got.led_state, got.out_of_range, got.drive_high,
                            got.drive_low, got.scan_row)});
            end
        end
    end

    // Count cycles in which no channel moves a transaction.
    always @(posedge i_clk) begin
        if (!i_rst_n || (item_ch.valid && item_ch.ready) || (res_ch.valid && res_ch.ready)
                || (cfg_ch.valid && cfg_ch.ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
    end

    initial begin : watchdog
        while (stall_cycles < STALL_LIMIT) @(posedge i_clk);
        $display("TEST FAILED");
        $finish;
    end

    initial begin : stimulus
        int phase_pins [9] = '{8, 2, 5, 3, 0, 15, 4, 7, 8};
        int phase_rows [9] = '{8, 1, 3, 3, 0, 15, 7, 2, 1};

        // Known values on every input before the first edge.
        i_rst_n           = 1'b0;
        item_ch.valid     = 1'b0;
        item_ch.kind      = cls_pkg::KIND_WRITE;
        item_ch.led_index = '0;
        item_ch.led_value = 1'b0;
        res_ch.ready      = 1'b0;
        cfg_ch.valid      = 1'b0;
        cfg_ch.index      = cls_pkg::REG_PIN_COUNT;
        cfg_ch.data       = '0;
        stall_cycles      = 0;
        fault_count       = 0;
        steady            = 1'b0;

        // Shadow state matches the block after reset.
        foreach (lamp_rows[i]) lamp_rows[i] = '0;
        scan_ptr    = '0;
        drive_latch = '0;
        pin_cfg     = cls_pkg::PIN_COUNT_RESET;
        row_cfg     = cls_pkg::ROW_COUNT_RESET;

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Full grid: corner LEDs, toggles, out-of-range indexes, unused kind, first rows.
        push_cmd(cls_pkg::KIND_WRITE, 0, 1'b1);
        push_cmd(cls_pkg::KIND_WRITE, 55, 1'b1);
        push_cmd(cls_pkg::KIND_TOGGLE, 55, 1'b0);
        push_cmd(cls_pkg::KIND_TOGGLE, 9, 1'b1);
        push_cmd(cls_pkg::KIND_WRITE, 6, 1'b1);
        push_cmd(cls_pkg::KIND_WRITE, 63, 1'b1);
        push_cmd(cls_pkg::KIND_TOGGLE, 56, 1'b0);
        push_cmd(KIND_UNUSED, 63, 1'b1);
        push_cmd(cls_pkg::KIND_TICK, 0, 1'b0);
        push_cmd(cls_pkg::KIND_TICK, 63, 1'b1);
        push_cmd(cls_pkg::KIND_TICK, 0, 1'b0);
        push_cmd(cls_pkg::KIND_WRITE, 48, 1'b0);

        // Shrink the row count below the scan pointer: the next tick falls back to row 0.
        set_config(4'd8, 4'd2);
        push_cmd(cls_pkg::KIND_TICK, 0, 1'b0);
        push_cmd(cls_pkg::KIND_TICK, 0, 1'b0);

        // Three pins: the upper slot bits stay stored but hidden.
        set_config(4'd3, 4'd3);
        push_cmd(cls_pkg::KIND_WRITE, 5, 1'b1);
        push_cmd(cls_pkg::KIND_WRITE, 6, 1'b1);
        push_cmd(cls_pkg::KIND_TOGGLE, 0, 1'b0);
        push_cmd(cls_pkg::KIND_TICK, 0, 1'b0);
        push_cmd(cls_pkg::KIND_TICK, 0, 1'b0);
        push_cmd(cls_pkg::KIND_TICK, 0, 1'b0);

        // Back to eight pins: the hidden bits show again on row 0.
        set_config(4'd8, 4'd1);
        push_cmd(cls_pkg::KIND_TICK, 0, 1'b0);
        push_cmd(cls_pkg::KIND_TICK, 0, 1'b0);

        // Random phases over a spread of settings, extremes and out-of-range values included.
        for (int p = 0; p < 9; p++) begin
            set_config(4'(phase_pins[p]), 4'(phase_rows[p]));
            steady = (p == 2);
            for (int n = 0; n < 90; n++) begin
                cmd_queue.push_back(random_cmd());
                // Hold the sender now and then until every result is back.
                if (p == 4 && n % 30 == 29) wait_drained();
            end
        end

        wait_drained();
        steady = 1'b0;
        repeat (20) @(posedge i_clk);
        if (fault_count == 0 && due_results.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

// ----- files.f -----
rtl/core/cls_pkg.sv
rtl/core/cls_if.sv
rtl/core/cls_ctrl.sv
rtl/core/cls_datapath.sv
rtl/core/charlieplex_led_scanner.sv
tb/sv/charlieplex_led_scanner_test.sv
